// ===== rtl/rvt_pkg.sv =====
`default_nettype none

package rvt_pkg;

    // Fixed-point formats
    localparam int ANGLE_FRAC_BITS  = 12;
    localparam int MATRIX_FRAC_BITS = 14;
    localparam int CORDIC_STEPS     = 16;

    localparam int POS_W   = 32;
    localparam int ROT_W   = 16;
    localparam int ENTRY_W = 16;

    // Sum of squares and its root, r = floor(sqrt(sum << 30))
    localparam int SUMSQ_W    = 2 * ROT_W;
    localparam int ROOT_W     = (SUMSQ_W + 30) / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 2;

    // Axis division: |v| * 2^45 / r, quotient Q30
    localparam int Q_FRAC    = 30;
    localparam int AXIS_W    = Q_FRAC + 2;
    localparam int QUOT_W    = Q_FRAC + 1;
    localparam int DIV_REM_W = ROOT_W + 2;

    // Quarter-turn reduction
    localparam int ANGLE_SCALE = ANGLE_FRAC_BITS + 15;
    localparam logic [63:0] PI_Q61  = 64'h6487ED5110B4611A;
    localparam logic [63:0] HALF_PI =
        (PI_Q61 + (64'd1 << (61 - ANGLE_SCALE))) >> (62 - ANGLE_SCALE);
    localparam int QUAD_STEPS = $clog2(((64'd1 << ROOT_W) / HALF_PI) + 64'd1);
    localparam int REM_SHL = (ANGLE_SCALE <= Q_FRAC) ? Q_FRAC - ANGLE_SCALE : 0;
    localparam int REM_SHR = (ANGLE_SCALE > Q_FRAC) ? ANGLE_SCALE - Q_FRAC : 0;

    // CORDIC
    localparam int CORDIC_N = (CORDIC_STEPS < 8) ? 8 :
                              ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);
    localparam int CW       = Q_FRAC + 4;
    localparam int GAIN_IDX = (CORDIC_N > 15) ? 7 : CORDIC_N - 8;

    localparam logic signed [CW-1:0] ATAN_Q30 [0:31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    localparam logic signed [CW-1:0] GAIN_Q30 [0:7] = '{
        652039507, 652034532, 652033289, 652032978,
        652032900, 652032881, 652032876, 652032874
    };

    localparam logic signed [CW-1:0] CORDIC_GAIN = GAIN_Q30[GAIN_IDX];

    // Matrix arithmetic widths
    localparam int T_W     = CW + 1;
    localparam int P1_W    = T_W + AXIS_W;
    localparam int R1_W    = P1_W - Q_FRAC;
    localparam int P2_W    = R1_W + AXIS_W;
    localparam int R2_W    = P2_W - Q_FRAC;
    localparam int SUM_W   = R2_W + 1;

    localparam int IN_DATA_W  = 3 * POS_W + 3 * ROT_W;
    localparam int OUT_DATA_W = 9 * ENTRY_W + 3 * POS_W;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Input request, first member in the highest bits
    typedef struct packed {
        logic signed [ROT_W-1:0] rot_z;
        logic signed [ROT_W-1:0] rot_y;
        logic signed [ROT_W-1:0] rot_x;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } item_t;

    typedef struct packed {
        logic                     zero;
        logic signed [AXIS_W-1:0] ux;
        logic signed [AXIS_W-1:0] uy;
        logic signed [AXIS_W-1:0] uz;
    } axis_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   t_z;
        logic signed [POS_W-1:0]   t_y;
        logic signed [POS_W-1:0]   t_x;
        logic signed [ENTRY_W-1:0] m_zz;
        logic signed [ENTRY_W-1:0] m_zy;
        logic signed [ENTRY_W-1:0] m_zx;
        logic signed [ENTRY_W-1:0] m_yz;
        logic signed [ENTRY_W-1:0] m_yy;
        logic signed [ENTRY_W-1:0] m_yx;
        logic signed [ENTRY_W-1:0] m_xz;
        logic signed [ENTRY_W-1:0] m_xy;
        logic signed [ENTRY_W-1:0] m_xx;
    } res_t;

    // Round half up from Q30 to the entry format, then saturate
    function automatic logic signed [ENTRY_W-1:0] to_entry(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] e;
        e = v;
        if (MATRIX_FRAC_BITS < Q_FRAC)
        begin
            e = (v + (SUM_W'(1) <<< (Q_FRAC - 1 - MATRIX_FRAC_BITS)))
                >>> (Q_FRAC - MATRIX_FRAC_BITS);
        end
        if (e > SUM_W'(32767))
        begin
            return ENTRY_W'(32767);
        end
        else if (e < -SUM_W'(32768))
        begin
            return ENTRY_W'(-32768);
        end
        return ENTRY_W'(e);
    endfunction

    localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = to_entry(SUM_W'(1) <<< Q_FRAC);

endpackage

`default_nettype wire

// ===== rtl/rvt_sqrt.sv =====
`default_nettype none

module rvt_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire rvt_pkg::item_t                in_item,
    output logic                               out_valid,
    output rvt_pkg::item_t                     out_item,
    output logic [rvt_pkg::ROOT_W-1:0]         out_root,
    output logic                               out_zero
);
    import rvt_pkg::*;

    logic                    sqv_reg;
    item_t                   sqi_reg;
    logic [SUMSQ_W-1:0]      sqx_reg, sqy_reg, sqz_reg;
    logic signed [SUMSQ_W-1:0] px, py, pz;

    logic                    v_reg    [0:ROOT_STEPS];
    item_t                   it_reg   [0:ROOT_STEPS];
    logic                    zero_reg [0:ROOT_STEPS];
    logic [SUMSQ_W-1:0]      sq_reg   [0:ROOT_STEPS];
    logic [ROOT_W-1:0]       root_reg [0:ROOT_STEPS];
    logic [SQ_REM_W-1:0]     rem_reg  [0:ROOT_STEPS];
    logic [ROOT_W-1:0]       root_next [0:ROOT_STEPS-1];
    logic [SQ_REM_W-1:0]     rem_next  [0:ROOT_STEPS-1];
    logic [SUMSQ_W-1:0]      sum_next;

    always_comb
    begin
        px = in_item.rot_x * in_item.rot_x;
        py = in_item.rot_y * in_item.rot_y;
        pz = in_item.rot_z * in_item.rot_z;
        sum_next = sqx_reg + sqy_reg + sqz_reg;
    end

    // One result bit per stage: bring down two bits, try subtracting 4*root+1
    always_comb
    begin
        logic [1:0]          pair;
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            pair = 2'b00;
            if (j < SUMSQ_W / 2)
            begin
                pair = 2'(sq_reg[j] >> (SUMSQ_W - 2 - 2 * j));
            end
            cur   = {rem_reg[j], pair};
            trial = {2'b00, root_reg[j], 2'b01};
            if (cur >= trial)
            begin
                rem_next[j]  = SQ_REM_W'(cur - trial);
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = SQ_REM_W'(cur);
                root_next[j] = {root_reg[j][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg <= 1'b0;
            for (int j = 0; j <= ROOT_STEPS; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            sqv_reg  <= in_valid;
            v_reg[0] <= sqv_reg;
            for (int j = 0; j < ROOT_STEPS; j++)
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqi_reg     <= in_item;
            sqx_reg     <= unsigned'(px);
            sqy_reg     <= unsigned'(py);
            sqz_reg     <= unsigned'(pz);
            it_reg[0]   <= sqi_reg;
            sq_reg[0]   <= sum_next;
            zero_reg[0] <= (sum_next == '0);
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            for (int j = 0; j < ROOT_STEPS; j++)
            begin
                it_reg[j+1]   <= it_reg[j];
                sq_reg[j+1]   <= sq_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                root_reg[j+1] <= root_next[j];
                rem_reg[j+1]  <= rem_next[j];
            end
        end
    end

    assign out_valid = v_reg[ROOT_STEPS];
    assign out_item  = it_reg[ROOT_STEPS];
    assign out_root  = root_reg[ROOT_STEPS];
    assign out_zero  = zero_reg[ROOT_STEPS];

endmodule

`default_nettype wire

// ===== rtl/rvt_axis.sv =====
`default_nettype none

module rvt_axis (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire rvt_pkg::item_t            in_item,
    input  wire logic [rvt_pkg::ROOT_W-1:0] in_root,
    input  wire logic                      in_zero,
    output logic                           out_valid,
    output rvt_pkg::item_t                 out_item,
    output logic [rvt_pkg::ROOT_W-1:0]     out_root,
    output rvt_pkg::axis_t                 out_axis
);
    import rvt_pkg::*;

    logic                 v_reg    [0:QUOT_W];
    item_t                it_reg   [0:QUOT_W];
    logic                 zero_reg [0:QUOT_W];
    logic [ROOT_W-1:0]    root_reg [0:QUOT_W];
    logic [DIV_REM_W-1:0] rem_reg  [0:QUOT_W][0:2];
    logic [QUOT_W-1:0]    q_reg    [0:QUOT_W][0:2];
    logic                 neg_reg  [0:QUOT_W][0:2];
    logic [DIV_REM_W-1:0] rem_next [0:QUOT_W-1][0:2];
    logic [QUOT_W-1:0]    q_next   [0:QUOT_W-1][0:2];
    logic [DIV_REM_W-1:0] rem0_next [0:2];
    logic                 neg0_next [0:2];
    logic signed [AXIS_W-1:0] u_next [0:2];

    logic                 ov_reg;
    item_t                oi_reg;
    logic [ROOT_W-1:0]    or_reg;
    axis_t                oa_reg;

    // Magnitude times 2^14 is the first partial remainder of |v| * 2^45 / r
    always_comb
    begin
        logic [ROT_W-1:0] comp [0:2];
        logic [ROT_W:0]   mag;
        comp[0] = in_item.rot_x;
        comp[1] = in_item.rot_y;
        comp[2] = in_item.rot_z;
        for (int l = 0; l < 3; l++)
        begin
            neg0_next[l] = comp[l][ROT_W-1];
            mag = comp[l][ROT_W-1] ? ((ROT_W+1)'(0) - {1'b1, comp[l]}) : {1'b0, comp[l]};
            rem0_next[l] = DIV_REM_W'({mag, (Q_FRAC + 15 - QUOT_W)'(0)});
        end
    end

    always_comb
    begin
        logic [DIV_REM_W:0] cur;
        logic [DIV_REM_W:0] dv;
        for (int j = 0; j < QUOT_W; j++)
        begin
            dv = {(DIV_REM_W+1-ROOT_W)'(0), root_reg[j]};
            for (int l = 0; l < 3; l++)
            begin
                cur = {rem_reg[j][l], 1'b0};
                if (cur >= dv)
                begin
                    rem_next[j][l] = DIV_REM_W'(cur - dv);
                    q_next[j][l]   = {q_reg[j][l][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][l] = DIV_REM_W'(cur);
                    q_next[j][l]   = {q_reg[j][l][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Clamp to 1.0 and restore the sign
    always_comb
    begin
        logic [QUOT_W-1:0] q;
        for (int l = 0; l < 3; l++)
        begin
            q = q_reg[QUOT_W][l];
            if (q > (QUOT_W'(1) << Q_FRAC))
            begin
                q = QUOT_W'(1) << Q_FRAC;
            end
            u_next[l] = neg_reg[QUOT_W][l] ? -signed'({1'b0, q}) : signed'({1'b0, q});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            for (int j = 0; j <= QUOT_W; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int j = 0; j < QUOT_W; j++)
            begin
                v_reg[j+1] <= v_reg[j];
            end
            ov_reg <= v_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0]   <= in_item;
            zero_reg[0] <= in_zero;
            root_reg[0] <= in_root;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= rem0_next[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg0_next[l];
            end
            for (int j = 0; j < QUOT_W; j++)
            begin
                it_reg[j+1]   <= it_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                root_reg[j+1] <= root_reg[j];
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[j+1][l] <= rem_next[j][l];
                    q_reg[j+1][l]   <= q_next[j][l];
                    neg_reg[j+1][l] <= neg_reg[j][l];
                end
            end
            oi_reg      <= it_reg[QUOT_W];
            or_reg      <= root_reg[QUOT_W];
            oa_reg.zero <= zero_reg[QUOT_W];
            oa_reg.ux   <= u_next[0];
            oa_reg.uy   <= u_next[1];
            oa_reg.uz   <= u_next[2];
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;
    assign out_root  = or_reg;
    assign out_axis  = oa_reg;

endmodule

`default_nettype wire

// ===== rtl/rvt_angle.sv =====
`default_nettype none

module rvt_angle (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire rvt_pkg::item_t             in_item,
    input  wire logic [rvt_pkg::ROOT_W-1:0] in_root,
    input  wire rvt_pkg::axis_t             in_axis,
    output logic                            out_valid,
    output rvt_pkg::item_t                  out_item,
    output rvt_pkg::axis_t                  out_axis,
    output logic signed [rvt_pkg::CW-1:0]   out_cos,
    output logic signed [rvt_pkg::CW-1:0]   out_sin
);
    import rvt_pkg::*;

    // Quarter-turn reduction, one quotient bit per stage
    logic              rv_reg   [0:QUAD_STEPS];
    item_t             ri_reg   [0:QUAD_STEPS];
    axis_t             ra_reg   [0:QUAD_STEPS];
    logic [ROOT_W-1:0] rr_reg   [0:QUAD_STEPS];
    logic [1:0]        rq_reg   [0:QUAD_STEPS];
    logic [ROOT_W-1:0] rr_next  [0:QUAD_STEPS-1];
    logic [1:0]        rq_next  [0:QUAD_STEPS-1];

    // CORDIC rotation, one micro-rotation per stage
    logic              cv_reg [0:CORDIC_N];
    item_t             ci_reg [0:CORDIC_N];
    axis_t             ca_reg [0:CORDIC_N];
    logic [1:0]        cq_reg [0:CORDIC_N];
    logic signed [CW-1:0] x_reg [0:CORDIC_N];
    logic signed [CW-1:0] y_reg [0:CORDIC_N];
    logic signed [CW-1:0] z_reg [0:CORDIC_N];
    logic signed [CW-1:0] x_next [0:CORDIC_N-1];
    logic signed [CW-1:0] y_next [0:CORDIC_N-1];
    logic signed [CW-1:0] z_next [0:CORDIC_N-1];
    logic signed [CW-1:0] z0_next;

    logic              ov_reg;
    item_t             oi_reg;
    axis_t             oa_reg;
    logic signed [CW-1:0] c_reg, s_reg, c_next, s_next;

    always_comb
    begin
        logic [63:0] sub;
        logic        kbit;
        for (int j = 0; j < QUAD_STEPS; j++)
        begin
            sub  = HALF_PI << (QUAD_STEPS - 1 - j);
            kbit = (64'(rr_reg[j]) >= sub);
            if (kbit)
            begin
                rr_next[j] = ROOT_W'(64'(rr_reg[j]) - sub);
            end
            else
            begin
                rr_next[j] = rr_reg[j];
            end
            rq_next[j] = {rq_reg[j][0], kbit};
        end
    end

    // Remainder to Q30
    always_comb
    begin
        z0_next = CW'((64'(rr_reg[QUAD_STEPS]) << REM_SHL) >> REM_SHR);
    end

    always_comb
    begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (z_reg[i] >= 0)
            begin
                x_next[i] = x_reg[i] - dx;
                y_next[i] = y_reg[i] + dy;
                z_next[i] = z_reg[i] - ATAN_Q30[i];
            end
            else
            begin
                x_next[i] = x_reg[i] + dx;
                y_next[i] = y_reg[i] - dy;
                z_next[i] = z_reg[i] + ATAN_Q30[i];
            end
        end
    end

    // Map (cos, sin) of the remainder to the whole angle by quadrant
    always_comb
    begin
        unique case (quad_t'(cq_reg[CORDIC_N]))
            QUAD_0:
            begin
                c_next = x_reg[CORDIC_N];
                s_next = y_reg[CORDIC_N];
            end
            QUAD_1:
            begin
                c_next = -y_reg[CORDIC_N];
                s_next = x_reg[CORDIC_N];
            end
            QUAD_2:
            begin
                c_next = -x_reg[CORDIC_N];
                s_next = -y_reg[CORDIC_N];
            end
            QUAD_3:
            begin
                c_next = y_reg[CORDIC_N];
                s_next = -x_reg[CORDIC_N];
            end
            default:
            begin
                c_next = x_reg[CORDIC_N];
                s_next = y_reg[CORDIC_N];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            for (int j = 0; j <= QUAD_STEPS; j++)
            begin
                rv_reg[j] <= 1'b0;
            end
            for (int i = 0; i <= CORDIC_N; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            rv_reg[0] <= in_valid;
            for (int j = 0; j < QUAD_STEPS; j++)
            begin
                rv_reg[j+1] <= rv_reg[j];
            end
            cv_reg[0] <= rv_reg[QUAD_STEPS];
            for (int i = 0; i < CORDIC_N; i++)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
            ov_reg <= cv_reg[CORDIC_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ri_reg[0] <= in_item;
            ra_reg[0] <= in_axis;
            rr_reg[0] <= in_root;
            rq_reg[0] <= '0;
            for (int j = 0; j < QUAD_STEPS; j++)
            begin
                ri_reg[j+1] <= ri_reg[j];
                ra_reg[j+1] <= ra_reg[j];
                rr_reg[j+1] <= rr_next[j];
                rq_reg[j+1] <= rq_next[j];
            end
            ci_reg[0] <= ri_reg[QUAD_STEPS];
            ca_reg[0] <= ra_reg[QUAD_STEPS];
            cq_reg[0] <= rq_reg[QUAD_STEPS];
            x_reg[0]  <= CORDIC_GAIN;
            y_reg[0]  <= '0;
            z_reg[0]  <= z0_next;
            for (int i = 0; i < CORDIC_N; i++)
            begin
                ci_reg[i+1] <= ci_reg[i];
                ca_reg[i+1] <= ca_reg[i];
                cq_reg[i+1] <= cq_reg[i];
                x_reg[i+1]  <= x_next[i];
                y_reg[i+1]  <= y_next[i];
                z_reg[i+1]  <= z_next[i];
            end
            oi_reg <= ci_reg[CORDIC_N];
            oa_reg <= ca_reg[CORDIC_N];
            c_reg  <= c_next;
            s_reg  <= s_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;
    assign out_axis  = oa_reg;
    assign out_cos   = c_reg;
    assign out_sin   = s_reg;

endmodule

`default_nettype wire

// ===== rtl/rvt_matrix.sv =====
`default_nettype none

module rvt_matrix (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire rvt_pkg::item_t            in_item,
    input  wire rvt_pkg::axis_t            in_axis,
    input  wire logic signed [rvt_pkg::CW-1:0] in_cos,
    input  wire logic signed [rvt_pkg::CW-1:0] in_sin,
    output logic                           out_valid,
    output rvt_pkg::res_t                  out_res
);
    import rvt_pkg::*;

    localparam int NSTG = 6;

    logic  v_reg    [0:NSTG];
    item_t it_reg   [0:NSTG-1];
    logic  zero_reg [0:NSTG-1];
    logic signed [CW-1:0] c_reg [0:NSTG-2];

    // Stage 0: t = 1 - cos
    logic signed [T_W-1:0]    t0_reg;
    logic signed [CW-1:0]     s0_reg;
    logic signed [AXIS_W-1:0] u_reg [0:2][0:2];

    // Stage 1: t*u and s*u
    logic signed [P1_W-1:0] pt1_reg [0:2];
    logic signed [P1_W-1:0] ps1_reg [0:2];

    // Stage 2: rounded to Q30
    logic signed [R1_W-1:0] tu2_reg [0:2];
    logic signed [R1_W-1:0] su2_reg [0:2];
    logic signed [R1_W-1:0] su3_reg [0:2];
    logic signed [R1_W-1:0] su4_reg [0:2];

    // Stage 3: second products xx, yy, zz, xy, xz, yz
    logic signed [P2_W-1:0] p3_reg [0:5];

    // Stage 4: rounded
    logic signed [R2_W-1:0] q4_reg [0:5];

    // Stage 5: sums, row-major
    logic signed [SUM_W-1:0] m5_reg [0:8];
    logic signed [SUM_W-1:0] m5_next [0:8];

    res_t res_reg, res_next;

    localparam logic signed [P1_W-1:0] RND1 = P1_W'(1) <<< (Q_FRAC - 1);
    localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) <<< (Q_FRAC - 1);

    always_comb
    begin
        logic signed [SUM_W-1:0] c;
        c = SUM_W'(c_reg[NSTG-2]);
        m5_next[0] = SUM_W'(q4_reg[0]) + c;
        m5_next[4] = SUM_W'(q4_reg[1]) + c;
        m5_next[8] = SUM_W'(q4_reg[2]) + c;
        m5_next[1] = SUM_W'(q4_reg[3]) + SUM_W'(su4_reg[2]);
        m5_next[3] = SUM_W'(q4_reg[3]) - SUM_W'(su4_reg[2]);
        m5_next[2] = SUM_W'(q4_reg[4]) - SUM_W'(su4_reg[1]);
        m5_next[6] = SUM_W'(q4_reg[4]) + SUM_W'(su4_reg[1]);
        m5_next[5] = SUM_W'(q4_reg[5]) + SUM_W'(su4_reg[0]);
        m5_next[7] = SUM_W'(q4_reg[5]) - SUM_W'(su4_reg[0]);
    end

    // Saturate into entries; a zero vector gives identity
    always_comb
    begin
        logic signed [ENTRY_W-1:0] e [0:8];
        for (int i = 0; i < 9; i++)
        begin
            if (zero_reg[NSTG-1])
            begin
                e[i] = (i % 4 == 0) ? ENTRY_ONE : '0;
            end
            else
            begin
                e[i] = to_entry(m5_reg[i]);
            end
        end
        res_next.m_xx = e[0];
        res_next.m_xy = e[1];
        res_next.m_xz = e[2];
        res_next.m_yx = e[3];
        res_next.m_yy = e[4];
        res_next.m_yz = e[5];
        res_next.m_zx = e[6];
        res_next.m_zy = e[7];
        res_next.m_zz = e[8];
        res_next.t_x  = it_reg[NSTG-1].pos_x;
        res_next.t_y  = it_reg[NSTG-1].pos_y;
        res_next.t_z  = it_reg[NSTG-1].pos_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NSTG; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < NSTG; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0]   <= in_item;
            zero_reg[0] <= in_axis.zero;
            c_reg[0]    <= in_cos;
            for (int i = 0; i < NSTG - 1; i++)
            begin
                it_reg[i+1]   <= it_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
            for (int i = 0; i < NSTG - 2; i++)
            begin
                c_reg[i+1] <= c_reg[i];
            end

            t0_reg <= (T_W'(1) <<< Q_FRAC) - T_W'(in_cos);
            s0_reg <= in_sin;
            u_reg[0][0] <= in_axis.ux;
            u_reg[0][1] <= in_axis.uy;
            u_reg[0][2] <= in_axis.uz;
            for (int k = 0; k < 2; k++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    u_reg[k+1][l] <= u_reg[k][l];
                end
            end

            for (int l = 0; l < 3; l++)
            begin
                pt1_reg[l] <= t0_reg * u_reg[0][l];
                ps1_reg[l] <= s0_reg * u_reg[0][l];
                tu2_reg[l] <= R1_W'((pt1_reg[l] + RND1) >>> Q_FRAC);
                su2_reg[l] <= R1_W'((ps1_reg[l] + RND1) >>> Q_FRAC);
                su3_reg[l] <= su2_reg[l];
                su4_reg[l] <= su3_reg[l];
            end

            p3_reg[0] <= tu2_reg[0] * u_reg[2][0];
            p3_reg[1] <= tu2_reg[1] * u_reg[2][1];
            p3_reg[2] <= tu2_reg[2] * u_reg[2][2];
            p3_reg[3] <= tu2_reg[0] * u_reg[2][1];
            p3_reg[4] <= tu2_reg[0] * u_reg[2][2];
            p3_reg[5] <= tu2_reg[1] * u_reg[2][2];

            for (int i = 0; i < 6; i++)
            begin
                q4_reg[i] <= R2_W'((p3_reg[i] + RND2) >>> Q_FRAC);
            end
            for (int i = 0; i < 9; i++)
            begin
                m5_reg[i] <= m5_next[i];
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[NSTG];
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== rtl/rotation_vector_to_transform.sv =====
// Rotation vector to rigid transform.
// Slave channel s_axis_* carries one request per transfer: a Q16.16 position
// and a rotation vector in radians (Q3.12) whose length is the angle.
// Master channel m_axis_* returns one 3x4 transform per request, in order:
// nine Q1.14 rotation entries from Rodrigues' formula (saturated) and the
// position copied into the translation row. A zero vector gives identity.
// The path from acceptance to m_axis_tvalid is made of the 33-stage
// square root (squares, sum, one root bit per stage), the 33-stage axis
// divider (one quotient bit per stage, three lanes), 23 stages of
// quarter-turn reduction and 16-step CORDIC, 7 stages of matrix products
// and rounding, and the output register. Throughput: one request per cycle
// while s_axis_tready is high; every stage moves on the same enable.
// Reset clears all valid bits; the pipeline is empty and ready after reset.
// When the receiver stalls, one more result lands in a skid register, then
// s_axis_tready drops and the whole pipeline holds in place until the
// output drains; nothing is dropped or repeated.
`default_nettype none

module rotation_vector_to_transform (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64],
    // rot_x[111:96], rot_y[127:112], rot_z[143:128]
    input  wire logic [rvt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // m_xx[15:0], m_xy[31:16], m_xz[47:32], m_yx[63:48], m_yy[79:64],
    // m_yz[95:80], m_zx[111:96], m_zy[127:112], m_zz[143:128],
    // t_x[175:144], t_y[207:176], t_z[239:208]
    output logic [rvt_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import rvt_pkg::*;

    logic              en;
    item_t             in_item;

    logic              sq_valid;
    item_t             sq_item;
    logic [ROOT_W-1:0] sq_root;
    logic              sq_zero;

    logic              ax_valid;
    item_t             ax_item;
    logic [ROOT_W-1:0] ax_root;
    axis_t             ax_axis;

    logic              an_valid;
    item_t             an_item;
    axis_t             an_axis;
    logic signed [CW-1:0] an_cos, an_sin;

    logic              mx_valid;
    res_t              mx_res;

    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              skid_valid_reg;
    res_t              skid_res_reg;

    // Pipeline advances whenever the skid register is free
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign in_item       = item_t'(s_axis_tdata);

    rvt_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_item   (in_item),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_root  (sq_root),
        .out_zero  (sq_zero)
    );

    rvt_axis u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .in_root   (sq_root),
        .in_zero   (sq_zero),
        .out_valid (ax_valid),
        .out_item  (ax_item),
        .out_root  (ax_root),
        .out_axis  (ax_axis)
    );

    rvt_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ax_valid),
        .in_item   (ax_item),
        .in_root   (ax_root),
        .in_axis   (ax_axis),
        .out_valid (an_valid),
        .out_item  (an_item),
        .out_axis  (an_axis),
        .out_cos   (an_cos),
        .out_sin   (an_sin)
    );

    rvt_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (an_valid),
        .in_item   (an_item),
        .in_axis   (an_axis),
        .in_cos    (an_cos),
        .in_sin    (an_sin),
        .out_valid (mx_valid),
        .out_res   (mx_res)
    );

    // Output register with skid: a result leaving the pipeline while the
    // output is held parks in the skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || mx_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (en && mx_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_valid_reg)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : mx_res;
        end
        else if (en && mx_valid)
        begin
            skid_res_reg <= mx_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import rvt_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pos_x, pos_y, pos_z (32 bits each), rot_x, rot_y, rot_z (16 bits each)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // m_xx .. m_zz (16 bits each, row-major), t_x, t_y, t_z (32 bits each)
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    res_t  transforms_due[$];
    int    errors = 0;
    bit    steady = 1'b0;     // no idling on either side
    bit    hold_req = 1'b0;   // ask the receiver for one long hold-off

    localparam longint unsigned QUARTER_TURN = (64'h6487ED5110B4611A + (64'd1 << 34)) >> 35;
    localparam int HOLD_CYCLES = 300;

    rotation_vector_to_transform dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

    // Q30 by Q30 product, rounded half up
    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // Round Q30 to the entry format, then saturate
    function automatic logic signed [ENTRY_W-1:0] q30_to_entry(longint v);
        longint e;
        e = (v + (64'sd1 <<< 15)) >>> 16;
        if (e > 32767)
        begin
            e = 32767;
        end
        if (e < -32768)
        begin
            e = -32768;
        end
        return e[ENTRY_W-1:0];
    endfunction

    function automatic longint unit_axis(longint v, longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        q = (mag << 45) / len;
        if (q > (64'd1 << 30))
        begin
            q = 64'd1 << 30;
        end
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic res_t rodrigues_transform(item_t it);
        res_t          res;
        longint        vx, vy, vz, x, y, z, dx, dy, c, s, t, ux, uy, uz;
        longint        txy, txz, tyz;
        longint        m[9];
        longint unsigned sq, num, len, bitv, k, rem;
        vx = longint'(it.rot_x);
        vy = longint'(it.rot_y);
        vz = longint'(it.rot_z);
        sq = vx * vx + vy * vy + vz * vz;
        if (sq == 0)
        begin
            foreach (m[i])
                m[i] = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
        end
        else
        begin
            // integer square root of sq << 30
            num = sq << 30;
            len = 0;
            bitv = 64'd1 << 62;
            while (bitv > num)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (num >= len + bitv)
                begin
                    num = num - (len + bitv);
                    len = (len >> 1) + bitv;
                end
                else
                begin
                    len = len >> 1;
                end
                bitv = bitv >> 2;
            end
            k = len / QUARTER_TURN;
            rem = (len - k * QUARTER_TURN) << 3;
            x = 652032874;
            y = 0;
            z = longint'(rem);
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_Q30[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_Q30[i]);
                end
            end
            case (quad_t'(k[1:0]))
                QUAD_0: begin c = x;  s = y;  end
                QUAD_1: begin c = -y; s = x;  end
                QUAD_2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
            ux = unit_axis(vx, len);
            uy = unit_axis(vy, len);
            uz = unit_axis(vz, len);
            t = (64'sd1 <<< 30) - c;
            txy = mul_q30(mul_q30(t, ux), uy);
            txz = mul_q30(mul_q30(t, ux), uz);
            tyz = mul_q30(mul_q30(t, uy), uz);
            m[0] = mul_q30(mul_q30(t, ux), ux) + c;
            m[4] = mul_q30(mul_q30(t, uy), uy) + c;
            m[8] = mul_q30(mul_q30(t, uz), uz) + c;
            m[1] = txy + mul_q30(s, uz);
            m[3] = txy - mul_q30(s, uz);
            m[2] = txz - mul_q30(s, uy);
            m[6] = txz + mul_q30(s, uy);
            m[5] = tyz + mul_q30(s, ux);
            m[7] = tyz - mul_q30(s, ux);
        end
        res.m_xx = q30_to_entry(m[0]);
        res.m_xy = q30_to_entry(m[1]);
        res.m_xz = q30_to_entry(m[2]);
        res.m_yx = q30_to_entry(m[3]);
        res.m_yy = q30_to_entry(m[4]);
        res.m_yz = q30_to_entry(m[5]);
        res.m_zx = q30_to_entry(m[6]);
        res.m_zy = q30_to_entry(m[7]);
        res.m_zz = q30_to_entry(m[8]);
        res.t_x = it.pos_x;
        res.t_y = it.pos_y;
        res.t_z = it.pos_z;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Send one request: optional random gap first, then hold until accepted
    task automatic send_request(item_t it);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        transforms_due.push_back(rodrigues_transform(it));
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (transforms_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic item_t make_request(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
        item_t it;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        it.rot_x = rx;
        it.rot_y = ry;
        it.rot_z = rz;
        return it;
    endfunction

    // Mostly modest and tiny angles, some full-range vectors and some axis-aligned
    function automatic item_t random_request();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return make_request(16'($urandom_range(0, 16383) - 8192),
                                16'($urandom_range(0, 16383) - 8192),
                                16'($urandom_range(0, 16383) - 8192));
        if (sel < 6)
            return make_request(16'($urandom_range(0, 15) - 8),
                                16'($urandom_range(0, 15) - 8),
                                16'($urandom_range(0, 15) - 8));
        if (sel < 8)
        begin
            case ($urandom_range(0, 2))
                0: return make_request(16'($urandom), 16'd0, 16'd0);
                1: return make_request(16'd0, 16'($urandom), 16'd0);
                default: return make_request(16'd0, 16'd0, 16'($urandom));
            endcase
        end
        return make_request(16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    task automatic test_directed();
        item_t it;
        it = make_request(16'd0, 16'd0, 16'd0);   // zero vector: identity
        send_request(it);
        it.pos_x = 32'h7FFFFFFF; it.pos_y = 32'h80000000; it.pos_z = 32'hFFFFFFFF;
        send_request(it);
        it.pos_x = 32'h80000000; it.pos_y = 32'h7FFFFFFF; it.pos_z = 32'h0;
        send_request(it);
        send_request(make_request(16'h7FFF, 16'h0000, 16'h0000));
        send_request(make_request(16'h8000, 16'h0000, 16'h0000));
        send_request(make_request(16'h0000, 16'h7FFF, 16'h0000));
        send_request(make_request(16'h0000, 16'h8000, 16'h0000));
        send_request(make_request(16'h0000, 16'h0000, 16'h7FFF));
        send_request(make_request(16'h0000, 16'h0000, 16'h8000));
        send_request(make_request(16'h8000, 16'h8000, 16'h8000));  // largest length
        send_request(make_request(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_request(make_request(16'h0001, 16'h0000, 16'h0000));  // tiny angle
        send_request(make_request(16'hFFFF, 16'h0001, 16'hFFFF));
        send_request(make_request(16'd6434, 16'h0000, 16'h0000));  // near a quarter turn
        send_request(make_request(16'd12868, 16'h0000, 16'h0000)); // near a half turn
        send_request(make_request(16'd19302, 16'h0000, 16'h0000)); // three quarters
        send_request(make_request(16'd25736, 16'h0000, 16'h0000)); // full turn
        send_request(make_request(16'd4096, 16'd4096, 16'h0000));  // axis rounding
        send_request(make_request(16'hAAAA, 16'h5555, 16'hAAAA));
        send_request(make_request(16'h5555, 16'hAAAA, 16'h5555));
        stop_sending();
    endtask

    // Long receiver hold-off while requests keep coming: the pipe fills and stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (150) send_request(random_request());
        stop_sending();
    endtask

    // Pause the sender until every outstanding transform has come back
    task automatic test_drain_pause();
        repeat (40) send_request(random_request());
        stop_sending();
        wait_drained();
        repeat (40) send_request(random_request());
        stop_sending();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count - 150)
                steady = 1'b1;
            send_request(random_request());
        end
        stop_sending();
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none when steady
    initial
    begin
        int n;
        forever
        begin
            if (steady)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Compare each accepted transform with the oldest one due
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (transforms_due.size() == 0)
            begin
                $display("unexpected transform at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = transforms_due.pop_front();
                if (got.m_xx !== want.m_xx) report_mismatch("m_xx", got.m_xx, want.m_xx);
                if (got.m_xy !== want.m_xy) report_mismatch("m_xy", got.m_xy, want.m_xy);
                if (got.m_xz !== want.m_xz) report_mismatch("m_xz", got.m_xz, want.m_xz);
                if (got.m_yx !== want.m_yx) report_mismatch("m_yx", got.m_yx, want.m_yx);
                if (got.m_yy !== want.m_yy) report_mismatch("m_yy", got.m_yy, want.m_yy);
                if (got.m_yz !== want.m_yz) report_mismatch("m_yz", got.m_yz, want.m_yz);
                if (got.m_zx !== want.m_zx) report_mismatch("m_zx", got.m_zx, want.m_zx);
                if (got.m_zy !== want.m_zy) report_mismatch("m_zy", got.m_zy, want.m_zy);
                if (got.m_zz !== want.m_zz) report_mismatch("m_zz", got.m_zz, want.m_zz);
                if (got.t_x !== want.t_x) report_mismatch("t_x", got.t_x, want.t_x);
                if (got.t_y !== want.t_y) report_mismatch("t_y", got.t_y, want.t_y);
                if (got.t_z !== want.t_z) report_mismatch("t_z", got.t_z, want.t_z);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(800);
        wait_drained();
        repeat (120) @(posedge clk);
        if (errors == 0 && transforms_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
